// ===== hw/rtl/pggfp_pkg.sv =====
package pggfp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_RED   = 3'd0,
    REG_GAIN_GREEN = 3'd1,
    REG_GAIN_BLUE  = 3'd2,
    REG_COLOR_MODE = 3'd3,
    REG_BW_THRESH  = 3'd4,
    REG_OUT_FORMAT = 3'd5,
    REG_ALPHA      = 3'd6
  } reg_idx_e;

  // colour handling codes
  typedef enum logic [1:0] {
    MODE_COLOR = 2'd0,
    MODE_GRAY  = 2'd1,
    MODE_BW    = 2'd2,
    MODE_GRAY2 = 2'd3
  } color_mode_e;

  // output packing codes
  typedef enum logic [1:0] {
    FMT_ARGB8888 = 2'd0,
    FMT_RGB555   = 2'd1,
    FMT_RGB332   = 2'd2,
    FMT_BIT      = 2'd3
  } out_format_e;

  // reset values of the configuration registers
  localparam logic [15:0] GAIN_RESET   = 16'd256;
  localparam logic [7:0]  THRESH_RESET = 8'd128;
  localparam logic [7:0]  ALPHA_RESET  = 8'hff;

  // floor(x / 3) as (x * DIV3_MUL) >> DIV3_SHIFT, exact for x <= 765
  localparam int unsigned DIV3_SHIFT = 11;
  localparam logic [9:0]  DIV3_MUL   = 10'd683;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        out_last;
  } pixel_out_t;

  // pixel after gain and saturation
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } gained_t;

  typedef struct packed {
    logic [15:0]  gain_red;
    logic [15:0]  gain_green;
    logic [15:0]  gain_blue;
    color_mode_e  color_mode;
    logic [7:0]   bw_threshold;
    out_format_e  out_format;
    logic [7:0]   alpha_byte;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/pggfp_front.sv =====
module pggfp_front import pggfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pixel_in_t in_data_i,
  input  cfg_t      cfg_i,
  input  q_stat_t   q_stat_i,
  output logic      push_o,
  output gained_t   push_data_o
);

  // channel times 8.8 gain, floor, clamp at 255
  function automatic logic [7:0] apply_gain(input logic [7:0] chan, input logic [15:0] gain);
    logic [23:0] prod;
    prod = chan * gain;
    apply_gain = (|prod[23:16]) ? 8'hff : prod[15:8];
  endfunction

  logic    vld_q, vld_d;
  gained_t data_q;
  logic    accept;

  // hold the stage while the queue is full
  assign in_stall_o  = vld_q & q_stat_i.full;
  assign push_o      = vld_q & ~q_stat_i.full;
  assign push_data_o = data_q;
  assign accept      = in_valid_i & ~in_stall_o;
  assign vld_d       = accept | (vld_q & q_stat_i.full);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // gain multipliers into the stage register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q.red   <= apply_gain(in_data_i.pixel_rgb[23:16], cfg_i.gain_red);
      data_q.green <= apply_gain(in_data_i.pixel_rgb[15:8], cfg_i.gain_green);
      data_q.blue  <= apply_gain(in_data_i.pixel_rgb[7:0], cfg_i.gain_blue);
      data_q.last  <= in_data_i.last_pixel;
    end
  end

endmodule

// ===== hw/rtl/pggfp_queue.sv =====
module pggfp_queue import pggfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  gained_t push_data_i,
  input  logic    pop_i,
  output gained_t pop_data_o,
  output q_stat_t stat_o
);

  gained_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/pggfp_back.sv =====
module pggfp_back import pggfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  q_stat_t    q_stat_i,
  input  gained_t    q_data_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output pixel_out_t out_data_o
);

  logic       out_vld_q, out_vld_d;
  pixel_out_t out_q, out_d;
  logic [7:0] acc_q, acc_d;
  logic [2:0] cnt_q, cnt_d;

  // take from the queue when the output register is free or draining
  assign pop_o       = ~q_stat_i.empty & (~out_vld_q | ~out_stall_i);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // gray conversion, packing and bit gathering
  always_comb begin
    logic [9:0]  sum;
    logic [19:0] prod;
    logic [7:0]  gray;
    logic [7:0]  r, g, b;
    logic        bit_val;
    logic [7:0]  acc_next;

    sum      = {2'b00, q_data_i.red} + {2'b00, q_data_i.green} + {2'b00, q_data_i.blue};
    prod     = sum * DIV3_MUL;
    gray     = prod[DIV3_SHIFT +: 8];
    r        = q_data_i.red;
    g        = q_data_i.green;
    b        = q_data_i.blue;
    bit_val  = 1'b0;
    acc_next = acc_q;

    out_vld_d = out_vld_q & out_stall_i;
    out_d     = out_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;

    if (cfg_i.color_mode == MODE_BW) begin
      gray = (gray >= cfg_i.bw_threshold) ? 8'hff : 8'h00;
    end
    if (cfg_i.color_mode != MODE_COLOR) begin
      r = gray;
      g = gray;
      b = gray;
    end

    if (pop_o) begin
      out_d.out_last = q_data_i.last;
      case (cfg_i.out_format)
        FMT_ARGB8888: begin
          out_d.out_word = {cfg_i.alpha_byte, r, g, b};
          out_vld_d      = 1'b1;
        end
        FMT_RGB555: begin
          out_d.out_word = {17'd0, r[7:3], g[7:3], b[7:3]};
          out_vld_d      = 1'b1;
        end
        FMT_RGB332: begin
          out_d.out_word = {24'd0, r[7:5], g[7:5], b[7:6]};
          out_vld_d      = 1'b1;
        end
        default: begin
          bit_val  = r[7] | g[7] | b[7];
          acc_next = {acc_q[6:0], bit_val};
          if (cnt_q == 3'd7) begin
            out_d.out_word = {24'd0, acc_next};
            out_vld_d      = 1'b1;
            acc_d          = 8'd0;
            cnt_d          = 3'd0;
          end else begin
            acc_d = acc_next;
            cnt_d = cnt_q + 3'd1;
          end
        end
      endcase
      // frame end drops any partial byte
      if (q_data_i.last) begin
        acc_d = 8'd0;
        cnt_d = 3'd0;
      end
    end
  end

  // control and gathering state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      acc_q     <= 8'd0;
      cnt_q     <= 3'd0;
    end else begin
      out_vld_q <= out_vld_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== hw/rtl/pixel_gain_gray_format_pack.sv =====
// the gain multipliers sit in the front register, packing in the back
// throughput: one pixel per cycle unless the output stalls; bit format gives one
//   result per eight pixels
// a two-entry queue between front and back holds pixels while the output stalls
// reset: asynchronous, clears valid flags, queue and bit gathering, and loads
//   gains of 1.0, colour mode, threshold 128, ARGB8888 format and alpha 0xff
module pixel_gain_gray_format_pack import pggfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pixel_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pixel_out_t  out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_q;
  logic     cfg_wr;
  reg_idx_e reg_idx;
  logic     q_push, q_pop;
  gained_t  q_wdata, q_rdata;
  q_stat_t  q_stat;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_red     <= GAIN_RESET;
      cfg_q.gain_green   <= GAIN_RESET;
      cfg_q.gain_blue    <= GAIN_RESET;
      cfg_q.color_mode   <= MODE_COLOR;
      cfg_q.bw_threshold <= THRESH_RESET;
      cfg_q.out_format   <= FMT_ARGB8888;
      cfg_q.alpha_byte   <= ALPHA_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN_RED:   cfg_q.gain_red     <= pwdata[15:0];
        REG_GAIN_GREEN: cfg_q.gain_green   <= pwdata[15:0];
        REG_GAIN_BLUE:  cfg_q.gain_blue    <= pwdata[15:0];
        REG_COLOR_MODE: cfg_q.color_mode   <= color_mode_e'(pwdata[1:0]);
        REG_BW_THRESH:  cfg_q.bw_threshold <= pwdata[7:0];
        REG_OUT_FORMAT: cfg_q.out_format   <= out_format_e'(pwdata[1:0]);
        REG_ALPHA:      cfg_q.alpha_byte   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_GAIN_RED:   prdata = {16'd0, cfg_q.gain_red};
      REG_GAIN_GREEN: prdata = {16'd0, cfg_q.gain_green};
      REG_GAIN_BLUE:  prdata = {16'd0, cfg_q.gain_blue};
      REG_COLOR_MODE: prdata = {30'd0, cfg_q.color_mode};
      REG_BW_THRESH:  prdata = {24'd0, cfg_q.bw_threshold};
      REG_OUT_FORMAT: prdata = {30'd0, cfg_q.out_format};
      REG_ALPHA:      prdata = {24'd0, cfg_q.alpha_byte};
      default:        prdata = 32'd0;
    endcase
  end

  // front: accept and apply gains
  pggfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  // queue between front and back
  pggfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .stat_o      (q_stat)
  );

  // back: gray, pack, gather
  pggfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .q_data_i    (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // queue never reports full and empty together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  // back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a push into a full queue never happens
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("push into full queue");

  // input stall only while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> q_stat.full)
    else $error("input stalled with queue room");

endmodule
